>>> rtl/fct_positivity_limit_3d_assert.svh
// assertion macros for the fct positivity limiter checker
// used by fpl_check.sv, no other dependencies
`ifndef FCT_POSITIVITY_LIMIT_3D_ASSERT_SVH
`define FCT_POSITIVITY_LIMIT_3D_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define FPL_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) else $error("fpl check failed");

// antecedent implies consequent in the next cycle, quiet during reset
`define FPL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fpl check failed");

`endif

>>> rtl/fpl_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and helpers for the fct positivity limiter
// no dependencies
package fpl_pkg;

  localparam int unsigned NUM_FLUX   = 6;
  localparam int unsigned DIV_STEPS  = 32;
  localparam int unsigned DIV_LAT    = DIV_STEPS + 1;
  localparam int unsigned PIPE_LEN   = 2 * DIV_LAT + 5;
  localparam int unsigned VLD_DIVA   = 1 + DIV_LAT;
  localparam int unsigned VLD_SUM    = VLD_DIVA + 1;

  typedef enum logic [1:0] {
    REG_TIME_STEP = 2'd0,
    REG_WIDTH_X   = 2'd1,
    REG_WIDTH_Y   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [30:0]                  mass;
    logic [NUM_FLUX-1:0][31:0]    flux;
    logic                         en;
    logic                         lim;
    logic [NUM_FLUX-1:0]          sel;
  } item_t;

  // outgoing flux sum of one direction: positive high plus magnitude of negative low
  function automatic logic [31:0] outflow(input logic [31:0] hi, input logic [31:0] lo);
    logic [31:0] a;
    logic [31:0] b;
    a = hi[31] ? 32'd0 : hi;
    b = lo[31] ? (~lo + 32'd1) : 32'd0;
    return a + b;
  endfunction

  function automatic logic [31:0] magnitude(input logic [31:0] f);
    return f[31] ? (~f + 32'd1) : f;
  endfunction

endpackage

>>> rtl/fct_positivity_limit_3d.sv
`timescale 1ns / 1ps
// positivity limiter for flux corrected transport, one grid cell per request
// throughput one request per cycle while the pipeline is not held
// the pipeline advances as one unit and holds whenever a result waits unaccepted
// the two 32-step divider pipelines set the depth
// rst (synchronous) clears valid flags and restores time step and cell widths to 1.0
module fct_positivity_limit_3d
  import fpl_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // cell_mass[30:0], flux_x_low, flux_x_high, flux_y_low, flux_y_high,
  // flux_z_low, flux_z_high, cell_height_z[254:223], zero pad
  input  logic [255:0] s_tdata,
  // limit_enable
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // out_flux_x_low, out_flux_x_high, out_flux_y_low, out_flux_y_high,
  // out_flux_z_low, out_flux_z_high
  output logic [191:0] m_tdata,
  // was_limited
  output logic         m_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  logic [31:0] time_step;
  logic [31:0] cell_width_x;
  logic [31:0] cell_width_y;
  logic [PIPE_LEN-1:0] vld;
  logic        adv;

  item_t       it1, it2, it3, it4;
  item_t       it3_next, it4_next;
  logic [31:0] sx1, sy1, sz1, dz1, dz2;
  logic [63:0] nx2, ny2, nz2;
  logic [31:0] qx, qy, qz;
  item_t       sa [0:DIV_STEPS];
  item_t       sb [0:DIV_STEPS];
  logic [31:0] mo3, mo4;
  logic [63:0] prod4 [0:NUM_FLUX-1];
  logic [31:0] qf    [0:NUM_FLUX-1];
  logic [NUM_FLUX-1:0][31:0] out_flux;
  logic        out_lim;

  logic [32:0] sum1;
  logic [31:0] sat1;
  logic [32:0] sum2;
  logic [31:0] mo_next;

  assign adv       = !vld[PIPE_LEN-1] || m_tready;
  assign s_tready  = adv;
  assign cfg_ready = 1'b1;
  assign m_tvalid  = vld[PIPE_LEN-1];
  assign m_tdata   = out_flux;
  assign m_tuser   = out_lim;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step    <= 32'h0001_0000;
      cell_width_x <= 32'h0001_0000;
      cell_width_y <= 32'h0001_0000;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TIME_STEP: time_step    <= cfg_data;
        REG_WIDTH_X:   cell_width_x <= cfg_data;
        REG_WIDTH_Y:   cell_width_y <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[PIPE_LEN-2:0], s_tvalid};
    end
  end

  // input capture and outgoing flux sums
  always_ff @(posedge clk) begin
    if (adv) begin
      it1.mass <= s_tdata[30:0];
      for (int i = 0; i < NUM_FLUX; i++) begin
        it1.flux[i] <= s_tdata[31+32*i +: 32];
      end
      it1.en  <= s_tuser;
      it1.lim <= 1'b0;
      it1.sel <= '0;
      sx1 <= outflow(s_tdata[94:63],  s_tdata[62:31]);
      sy1 <= outflow(s_tdata[158:127], s_tdata[126:95]);
      sz1 <= outflow(s_tdata[222:191], s_tdata[190:159]);
      dz1 <= s_tdata[254:223];
    end
  end

  // dt times outflow
  always_ff @(posedge clk) begin
    if (adv) begin
      it2 <= it1;
      dz2 <= dz1;
      nx2 <= {32'd0, time_step} * {32'd0, sx1};
      ny2 <= {32'd0, time_step} * {32'd0, sy1};
      nz2 <= {32'd0, time_step} * {32'd0, sz1};
    end
  end

  fpl_div u_div_x (.clk(clk), .en(adv), .num(nx2), .den(cell_width_x), .quo(qx));
  fpl_div u_div_y (.clk(clk), .en(adv), .num(ny2), .den(cell_width_y), .quo(qy));
  fpl_div u_div_z (.clk(clk), .en(adv), .num(nz2), .den(dz2),          .quo(qz));

  always_ff @(posedge clk) begin
    if (adv) begin
      sa[0] <= it2;
      for (int k = 1; k <= DIV_STEPS; k++) begin
        sa[k] <= sa[k-1];
      end
    end
  end

  // saturating sum of the three terms and the limit decision
  always_comb begin
    sum1    = {1'b0, qx} + {1'b0, qy};
    sat1    = sum1[32] ? '1 : sum1[31:0];
    sum2    = {1'b0, sat1} + {1'b0, qz};
    mo_next = sum2[32] ? '1 : sum2[31:0];
  end

  always_comb begin
    it3_next     = sa[DIV_STEPS];
    it3_next.lim = sa[DIV_STEPS].en && (mo_next > {1'b0, sa[DIV_STEPS].mass});
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it3 <= it3_next;
      mo3 <= mo_next;
    end
  end

  // magnitude times mass for every flux, pick the outgoing ones
  always_comb begin
    it4_next = it3;
    for (int i = 0; i < NUM_FLUX; i++) begin
      if (i % 2 == 0) begin
        it4_next.sel[i] = it3.lim && it3.flux[i][31];
      end else begin
        it4_next.sel[i] = it3.lim && !it3.flux[i][31] && (it3.flux[i] != 32'd0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it4 <= it4_next;
      mo4 <= mo3;
      for (int i = 0; i < NUM_FLUX; i++) begin
        prod4[i] <= {32'd0, magnitude(it3.flux[i])} * {33'd0, it3.mass};
      end
    end
  end

  for (genvar i = 0; i < NUM_FLUX; i++) begin : g_scale
    fpl_div u_div (.clk(clk), .en(adv), .num(prod4[i]), .den(mo4), .quo(qf[i]));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb[0] <= it4;
      for (int k = 1; k <= DIV_STEPS; k++) begin
        sb[k] <= sb[k-1];
      end
    end
  end

  // restore sign on scaled fluxes, pass the unselected fluxes through unchanged
  always_ff @(posedge clk) begin
    if (adv) begin
      out_lim <= sb[DIV_STEPS].lim;
      for (int i = 0; i < NUM_FLUX; i++) begin
        if (sb[DIV_STEPS].sel[i]) begin
          out_flux[i] <= sb[DIV_STEPS].flux[i][31] ? (~qf[i] + 32'd1) : qf[i];
        end else begin
          out_flux[i] <= sb[DIV_STEPS].flux[i];
        end
      end
    end
  end

endmodule

>>> rtl/fpl_div.sv
`timescale 1ns / 1ps
// pipelined restoring divider, 64 by 32 bits, one quotient bit per stage
// saturates to all ones on overflow, zero divisor handled; uses fpl_pkg
module fpl_div
  import fpl_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] num,
  input  logic [31:0] den,
  output logic [31:0] quo
);

  logic [31:0] rem  [0:DIV_STEPS];
  logic [31:0] low  [0:DIV_STEPS];
  logic [31:0] qb   [0:DIV_STEPS];
  logic [31:0] dv   [0:DIV_STEPS];
  logic        sat  [0:DIV_STEPS];
  logic        dzero[0:DIV_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]   <= num[63:32];
      low[0]   <= num[31:0];
      qb[0]    <= '0;
      dv[0]    <= den;
      sat[0]   <= (num[63:32] >= den) && (num != 64'd0);
      dzero[0] <= (den == 32'd0);
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [32:0] t;
    logic [32:0] diff;
    logic        ge;
    always_comb begin
      t    = {rem[k], low[k][31]};
      diff = t - {1'b0, dv[k]};
      ge   = t >= {1'b0, dv[k]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]   <= ge ? diff[31:0] : t[31:0];
        low[k+1]   <= {low[k][30:0], 1'b0};
        qb[k+1]    <= {qb[k][30:0], ge};
        dv[k+1]    <= dv[k];
        sat[k+1]   <= sat[k];
        dzero[k+1] <= dzero[k];
      end
    end
  end

  assign quo = sat[DIV_STEPS] ? '1 : (dzero[DIV_STEPS] ? '0 : qb[DIV_STEPS]);

endmodule

>>> rtl/fpl_check.sv
`timescale 1ns / 1ps
// port level checks for the fct positivity limiter, bound to the top level
// uses fct_positivity_limit_3d_assert.svh
`include "fct_positivity_limit_3d_assert.svh"

module fpl_check (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [191:0] m_tdata,
  input logic         m_tuser
);

  `FPL_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
  `FPL_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser))
  `FPL_ASSERT_SAME(a_ready_follows_out, !rst, s_tready == (!m_tvalid || m_tready))
  `FPL_ASSERT_SAME(a_empty_after_reset, $past(rst), !m_tvalid)

endmodule

bind fct_positivity_limit_3d fpl_check u_check (.*);

>>> sim/fpl_scoreboard.sv
`timescale 1ns / 1ps
// checker for the fct positivity limiter: watches the request, result and register channels,
// predicts each result from its own copy of the registers and compares field by field
// depends on fpl_pkg for the register index names
module fpl_scoreboard
  import fpl_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [255:0] s_tdata,
  input  logic         s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [191:0] m_tdata,
  input  logic         m_tuser,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  output int           fail_count,
  output int           pending
);

  typedef struct packed {
    logic [5:0][31:0] flux;
    logic             limited;
  } limited_cell_t;

  logic [31:0] dt_q, dx_q, dy_q;
  limited_cell_t expected_q[$];

  assign pending = expected_q.size();

  function automatic logic [31:0] outgoing_term(logic [31:0] hi, logic [31:0] lo,
                                                logic [31:0] size);
    logic [63:0] s;
    logic [63:0] num;
    logic [63:0] q;
    s = 64'd0;
    if (!hi[31]) s += hi;
    if (lo[31]) s += 64'h1_0000_0000 - lo;
    num = dt_q * s;
    if (size == 0) return (num == 0) ? 32'd0 : 32'hFFFF_FFFF;
    q = num / size;
    return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
  endfunction

  function automatic logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
    logic [32:0] t;
    t = a + b;
    return t[32] ? 32'hFFFF_FFFF : t[31:0];
  endfunction

  function automatic logic [31:0] scale_toward_zero(logic [31:0] f, logic [31:0] m,
                                                    logic [31:0] mo);
    logic [63:0] mag;
    logic [63:0] r;
    mag = f[31] ? 64'h1_0000_0000 - f : {32'd0, f};
    r = (mag * m) / mo;
    return f[31] ? (32'd0 - r[31:0]) : r[31:0];
  endfunction

  function automatic limited_cell_t limit_cell(logic [255:0] d, logic en);
    limited_cell_t c;
    logic [31:0] mass;
    logic [31:0] mo;
    mass = {1'b0, d[30:0]};
    for (int i = 0; i < 6; i++) c.flux[i] = d[31 + 32*i +: 32];
    c.limited = 1'b0;
    if (en) begin
      mo = outgoing_term(c.flux[1], c.flux[0], dx_q);
      mo = add_sat(mo, outgoing_term(c.flux[3], c.flux[2], dy_q));
      mo = add_sat(mo, outgoing_term(c.flux[5], c.flux[4], d[254:223]));
      if (mo > mass) begin
        c.limited = 1'b1;
        for (int i = 0; i < 6; i += 2) begin
          if (c.flux[i][31]) c.flux[i] = scale_toward_zero(c.flux[i], mass, mo);
          if (!c.flux[i+1][31] && c.flux[i+1] != 0)
            c.flux[i+1] = scale_toward_zero(c.flux[i+1], mass, mo);
        end
      end
    end
    return c;
  endfunction

  always @(posedge clk) begin
    limited_cell_t exp_c;
    if (rst) begin
      dt_q <= 32'h0001_0000;
      dx_q <= 32'h0001_0000;
      dy_q <= 32'h0001_0000;
      fail_count <= 0;
      expected_q.delete();
    end else begin
      if (s_tvalid && s_tready) expected_q.push_back(limit_cell(s_tdata, s_tuser));
      if (m_tvalid && m_tready) begin
        if (expected_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %h %b", m_tdata, m_tuser);
          fail_count <= fail_count + 1;
        end else begin
          exp_c = expected_q.pop_front();
          if (exp_c.flux !== m_tdata || exp_c.limited !== m_tuser) begin
            if (fail_count < 10)
              $display("mismatch: expected %h %b, got %h %b",
                       exp_c.flux, exp_c.limited, m_tdata, m_tuser);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_TIME_STEP: dt_q <= cfg_data;
          REG_WIDTH_X:   dx_q <= cfg_data;
          REG_WIDTH_Y:   dy_q <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

>>> sim/tb_fct_positivity_limit_3d.sv
`timescale 1ns / 1ps
// top of the fct positivity limiter testbench: clock, reset, register phases and cell stimulus
// depends on fct_positivity_limit_3d, fpl_pkg and fpl_scoreboard
module tb_fct_positivity_limit_3d;
  import fpl_pkg::*;

  localparam int LATENCY = 71;
  localparam int STALL_LIMIT = 5000;

  logic clk, rst;
  logic s_tvalid, s_tready, s_tuser;
  logic [255:0] s_tdata;
  logic m_tvalid, m_tready, m_tuser;
  logic [191:0] m_tdata;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;
  int fail_count, pending, idle_cycles;
  logic rx_on;

  fct_positivity_limit_3d dut (.*);

  fpl_scoreboard checker_i (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // watchdog on cycles with no transfer accepted on any channel
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else if (idle_cycles + 1 >= STALL_LIMIT) begin
      $display("FAIL fct_positivity_limit_3d");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  // result side stalls
  initial begin
    int w;
    m_tready = 0;
    wait (rx_on === 1'b1);
    forever begin
      @(negedge clk);
      w = (rx_on) ? $urandom_range(0, 3) : 0;
      if (w == 0) m_tready = 1;
      else begin
        m_tready = 0;
        repeat (w - 1) @(negedge clk);
        @(negedge clk);
        m_tready = 1;
      end
      do @(posedge clk); while (!m_tvalid);
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic send_cell(logic [30:0] mass, logic [5:0][31:0] flux, logic [31:0] dz,
                           logic en, bit gaps);
    int w;
    w = gaps ? $urandom_range(0, 3) : 0;
    @(negedge clk);
    if (w > 0) begin
      s_tvalid = 0;
      repeat (w) @(negedge clk);
    end
    s_tvalid = 1;
    s_tdata = {1'b0, dz, flux, mass};
    s_tuser = en;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain;
    @(negedge clk);
    s_tvalid = 0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_flux(int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      2: return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
      default: return {$urandom_range(0, 1) ? 8'hFF : 8'h00, 24'($urandom())};
    endcase
  endfunction

  task automatic random_cells(int n);
    logic [5:0][31:0] f;
    logic [30:0] m;
    logic [31:0] dz;
    int mode;
    bit gaps;
    for (int k = 0; k < n; k++) begin
      mode = $urandom_range(0, 3);
      for (int i = 0; i < 6; i++) f[i] = rand_flux(mode);
      case ($urandom_range(0, 3))
        0: m = 31'($urandom());
        1: m = 31'($urandom_range(0, 32'h0008_0000));
        2: m = 0;
        default: m = 31'($urandom_range(0, 32'h0100_0000));
      endcase
      case ($urandom_range(0, 4))
        0: dz = $urandom();
        1: dz = 32'hFFFF_FFFF;
        2: dz = 0;
        default: dz = $urandom_range(32'h0000_4000, 32'h0004_0000);
      endcase
      gaps = ((k / 40) % 3) != 0;
      send_cell(m, f, dz, $urandom_range(0, 7) != 0, gaps);
    end
  endtask

  initial begin
    logic [5:0][31:0] f;
    rst = 1;
    rx_on = 0;
    s_tvalid = 0;
    s_tdata = '0;
    s_tuser = 0;
    cfg_valid = 0;
    cfg_index = REG_TIME_STEP;
    cfg_data = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 0;
    rx_on = 1;

    // directed cells at reset settings
    f = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h0, 32'h0};
    send_cell(31'h7FFF_FFFF, f, 32'hFFFF_FFFF, 1, 0);
    send_cell(31'd0, f, 32'h0001_0000, 1, 0);
    send_cell(31'd0, f, 32'h0001_0000, 0, 0);
    send_cell(31'd0, f, 32'd0, 1, 0);
    f = '{32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0, 32'h0};
    send_cell(31'd0, f, 32'd0, 1, 0);
    send_cell(31'd1, f, 32'd1, 1, 0);
    f = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
          32'h7FFF_FFFF, 32'h7FFF_FFFF};
    send_cell(31'h7FFF_FFFF, f, 32'd1, 1, 0);
    send_cell(31'h4000_0000, f, 32'hFFFF_FFFF, 1, 0);
    // cells whose outgoing mass stays below the cell mass
    f = '{32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'hFFFF_0000, 32'h0};
    send_cell(31'h0003_0000, f, 32'h0001_0000, 1, 0);
    send_cell(31'h0002_FFFF, f, 32'h0001_0000, 1, 0);
    send_cell(31'h0002_FFFF, ~f, 32'h0000_8000, 1, 0);
    drain();

    // extreme register settings, zero widths included
    write_reg(REG_TIME_STEP, 32'hFFFF_FFFF);
    write_reg(REG_WIDTH_X, 32'd0);
    write_reg(REG_WIDTH_Y, 32'hFFFF_FFFF);
    random_cells(150);
    drain();
    write_reg(REG_TIME_STEP, 32'd0);
    write_reg(REG_WIDTH_X, 32'hFFFF_FFFF);
    write_reg(REG_WIDTH_Y, 32'd0);
    random_cells(80);
    drain();
    write_reg(REG_TIME_STEP, 32'd1);
    write_reg(REG_WIDTH_X, 32'd1);
    write_reg(REG_WIDTH_Y, 32'd1);
    random_cells(100);
    drain();
    repeat (3) begin
      write_reg(REG_TIME_STEP, $urandom_range(32'h0000_1000, 32'h0004_0000));
      write_reg(REG_WIDTH_X, $urandom());
      write_reg(REG_WIDTH_Y, $urandom_range(32'h0000_4000, 32'h0004_0000));
      random_cells(110);
      drain();
    end

    if (fail_count == 0) $display("PASS fct_positivity_limit_3d");
    else $display("FAIL fct_positivity_limit_3d");
    $finish;
  end

endmodule
